[rtl/mpcr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the row prime-count argmax block.
// Used by mpcr_prime_test, mpcr_ram users and max_prime_count_rows; no dependencies.

package mpcr_pkg;

    // Defaults for the top-level size parameters
    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int ROW_IDX_W  = 4;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLS = 1'b1;
    localparam logic [CFG_DATA_W-1:0] NUM_ROWS_RST = 5'd4;
    localparam logic [CFG_DATA_W-1:0] NUM_COLS_RST = 5'd4;

    // Row prime count saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // Trial-division unit: remainder bits retired per cycle and derived sizes
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = VALUE_W / DIV_BITS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int DIVISOR_W  = 16;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int SQ_W       = 32;

    // Status from the primality unit to the top-level sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic is_prime;
    } t_prime_status;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FLUSH,
        ST_NONE
    } t_state;

    // Primality unit sequencer
    typedef enum logic [1:0] {
        PT_IDLE,
        PT_CHECK,
        PT_DIV,
        PT_EVAL
    } t_pt_state;

endpackage

[rtl/mpcr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mpcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/mpcr_prime_test.sv]
`timescale 1ns / 1ps
// Iterative primality test by trial division over divisors 2, 3, 5, 7, ...
// One shared remainder unit retires DIV_BITS dividend bits per cycle. Uses mpcr_pkg.

module mpcr_prime_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mpcr_pkg::VALUE_W-1:0]  i_value,
    output mpcr_pkg::t_prime_status       o_status
);

    mpcr_pkg::t_pt_state r_state, n_state;

    logic [mpcr_pkg::VALUE_W-2:0]    r_n;
    logic [mpcr_pkg::DIVISOR_W-1:0]  r_d;
    logic [mpcr_pkg::SQ_W-1:0]       r_sq;
    logic [mpcr_pkg::REM_W-1:0]      r_rem;
    logic [mpcr_pkg::VALUE_W-1:0]    r_shift;
    logic [mpcr_pkg::STEP_CNT_W-1:0] r_step;
    logic                            r_done;
    logic                            r_prime;

    logic [mpcr_pkg::REM_W-1:0]      w_rem_step;
    logic [mpcr_pkg::VALUE_W-1:0]    w_shift_step;
    logic                            w_finish;
    logic                            w_verdict;
    logic                            w_small;
    logic                            w_sq_over;
    logic                            w_last_step;
    logic [mpcr_pkg::DIVISOR_W-1:0]  w_d_next;
    logic [mpcr_pkg::SQ_W-1:0]       w_sq_delta;

    assign w_small     = (r_n < (mpcr_pkg::VALUE_W-1)'(2));
    assign w_sq_over   = (r_sq > mpcr_pkg::SQ_W'(r_n));
    assign w_last_step = (r_step == mpcr_pkg::STEP_CNT_W'(mpcr_pkg::DIV_STEPS - 1));

    // Restoring remainder steps, MSB first
    always_comb begin
        w_rem_step   = r_rem;
        w_shift_step = r_shift;
        for (int i = 0; i < mpcr_pkg::DIV_BITS; i++) begin
            w_rem_step   = {w_rem_step[mpcr_pkg::REM_W-2:0], w_shift_step[mpcr_pkg::VALUE_W-1]};
            w_shift_step = {w_shift_step[mpcr_pkg::VALUE_W-2:0], 1'b0};
            if (w_rem_step >= {1'b0, r_d}) begin
                w_rem_step = w_rem_step - {1'b0, r_d};
            end
        end
    end

    // Advance to the next odd divisor; (d+2)^2 = d^2 + 4d + 4
    always_comb begin
        if (r_d == mpcr_pkg::DIVISOR_W'(2)) begin
            w_d_next   = mpcr_pkg::DIVISOR_W'(3);
            w_sq_delta = mpcr_pkg::SQ_W'(5);
        end else begin
            w_d_next   = r_d + mpcr_pkg::DIVISOR_W'(2);
            w_sq_delta = mpcr_pkg::SQ_W'({r_d, 2'b00}) + mpcr_pkg::SQ_W'(4);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpcr_pkg::PT_IDLE: begin
                if (i_start) begin
                    n_state = mpcr_pkg::PT_CHECK;
                end
            end
            mpcr_pkg::PT_CHECK: begin
                n_state = (w_small || w_sq_over) ? mpcr_pkg::PT_IDLE : mpcr_pkg::PT_DIV;
            end
            mpcr_pkg::PT_DIV: begin
                if (w_last_step) begin
                    n_state = mpcr_pkg::PT_EVAL;
                end
            end
            mpcr_pkg::PT_EVAL: begin
                n_state = (r_rem == '0) ? mpcr_pkg::PT_IDLE : mpcr_pkg::PT_CHECK;
            end
            default: n_state = mpcr_pkg::PT_IDLE;
        endcase
    end

    // Outputs: finish and verdict
    always_comb begin
        w_finish  = 1'b0;
        w_verdict = 1'b0;
        unique case (r_state)
            mpcr_pkg::PT_CHECK: begin
                w_finish  = w_small || w_sq_over;
                w_verdict = !w_small && w_sq_over;
            end
            mpcr_pkg::PT_EVAL: begin
                w_finish  = (r_rem == '0);
                w_verdict = 1'b0;
            end
            default: begin
                w_finish  = 1'b0;
                w_verdict = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpcr_pkg::PT_IDLE;
            r_done  <= 1'b0;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_finish;
            r_prime <= w_verdict;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mpcr_pkg::PT_IDLE: begin
                if (i_start) begin
                    // negative values count as zero, hence not prime
                    r_n  <= i_value[mpcr_pkg::VALUE_W-1] ? '0 : i_value[mpcr_pkg::VALUE_W-2:0];
                    r_d  <= mpcr_pkg::DIVISOR_W'(2);
                    r_sq <= mpcr_pkg::SQ_W'(4);
                end
            end
            mpcr_pkg::PT_CHECK: begin
                r_rem   <= '0;
                r_shift <= {1'b0, r_n};
                r_step  <= '0;
            end
            mpcr_pkg::PT_DIV: begin
                r_rem   <= w_rem_step;
                r_shift <= w_shift_step;
                r_step  <= r_step + mpcr_pkg::STEP_CNT_W'(1);
            end
            mpcr_pkg::PT_EVAL: begin
                r_d  <= w_d_next;
                r_sq <= r_sq + w_sq_delta;
            end
            default: begin
            end
        endcase
    end

    assign o_status.busy     = (r_state != mpcr_pkg::PT_IDLE);
    assign o_status.done     = r_done;
    assign o_status.is_prime = r_prime;

endmodule

[rtl/max_prime_count_rows.sv]
`timescale 1ns / 1ps
// Top level of the row prime-count argmax block: input handshake, row/column
// bookkeeping, per-row count store and result scan. Uses mpcr_pkg, mpcr_ram, mpcr_prime_test.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata[31:0] = value (signed)
// m_axis    out  m_axis_tvalid/tready         tdata[3:0] = row_index, [8:4] = max_count,
//                                             tuser = none_found, tlast = last
// cfg       in   i_cfg_wr_en (no wait)        i_cfg_addr: 0 num_rows, 1 num_cols
//
// One element at a time: s_axis_tready is high only in the idle state. An element's
// test tries T divisors: T = 0 below 4 and T = 1 + floor((floor(sqrt(n)) - 1) / 2)
// for a prime n >= 4. Each trial runs a check, the remainder steps of the shared
// 4-bit-per-cycle remainder unit in mpcr_prime_test, and a divisor update. After the
// last element the count store is scanned row by row, each row read and then compared;
// a stalled m_axis holds the scan.
// Reset (synchronous, active low) clears the sequencers and the run; the count store
// needs no clearing pass.

module max_prime_count_rows #(
    parameter int MAX_ROWS = mpcr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mpcr_pkg::MAX_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mpcr_pkg::VALUE_W-1:0]      s_axis_tdata,   // [31:0] value
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mpcr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [3:0] row_index, [8:4] max_count
    output logic                              m_axis_tuser,   // [0] none_found
    output logic                              m_axis_tlast,
    // configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [mpcr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mpcr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_CW = $clog2(MAX_COLS + 1);

    mpcr_pkg::t_state r_state, n_state;

    // configuration
    logic [mpcr_pkg::CFG_DATA_W-1:0] r_num_rows;
    logic [mpcr_pkg::CFG_DATA_W-1:0] r_num_cols;

    // run bookkeeping
    logic [COL_CW-1:0]             r_col;
    logic [ROW_CW-1:0]             r_row;
    logic [mpcr_pkg::COUNT_W-1:0]  r_cur;
    logic [mpcr_pkg::COUNT_W-1:0]  r_best;

    // result scan
    logic [ROW_CW-1:0]             r_scan;
    logic [ROW_AW-1:0]             r_pend_row;
    logic                          r_pend_valid;

    // output register
    logic                          r_out_valid;
    logic [mpcr_pkg::ROW_IDX_W-1:0] r_out_row;
    logic [mpcr_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_none;
    logic                          r_out_last;

    mpcr_pkg::t_prime_status       w_pt_status;
    logic [mpcr_pkg::COUNT_W-1:0]  w_rd_data;

    logic [ROW_CW-1:0]             w_rows;
    logic [COL_CW-1:0]             w_cols;
    logic                          w_in_accept;
    logic                          w_elem_done;
    logic [mpcr_pkg::COUNT_W-1:0]  w_cur_inc;
    logic [mpcr_pkg::COUNT_W-1:0]  w_best_next;
    logic                          w_row_end;
    logic                          w_mat_end;
    logic                          w_scan_end;
    logic                          w_match;
    logic                          w_out_free;
    logic                          w_stall;
    logic                          w_ram_wr;

    // push into the output register
    logic                          w_push;
    logic [mpcr_pkg::ROW_IDX_W-1:0] w_push_row;
    logic [mpcr_pkg::COUNT_W-1:0]  w_push_count;
    logic                          w_push_none;
    logic                          w_push_last;

    // ------------------------------------------------------------------
    // Configuration registers: written any cycle, no read-back
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= mpcr_pkg::NUM_ROWS_RST;
            r_num_cols <= mpcr_pkg::NUM_COLS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                mpcr_pkg::CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                mpcr_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp sizes: zero acts as one, anything above the parameter as the parameter
    always_comb begin
        priority if (r_num_rows == '0) begin
            w_rows = ROW_CW'(1);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            w_rows = ROW_CW'(MAX_ROWS);
        end else begin
            w_rows = ROW_CW'(r_num_rows);
        end
        priority if (r_num_cols == '0) begin
            w_cols = COL_CW'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            w_cols = COL_CW'(MAX_COLS);
        end else begin
            w_cols = COL_CW'(r_num_cols);
        end
    end

    // ------------------------------------------------------------------
    // Primality unit
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == mpcr_pkg::ST_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    mpcr_prime_test u_prime_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in_accept),
        .i_value  (s_axis_tdata),
        .o_status (w_pt_status)
    );

    // ------------------------------------------------------------------
    // Element bookkeeping once the verdict is in
    // ------------------------------------------------------------------
    assign w_elem_done = (r_state == mpcr_pkg::ST_TEST) && w_pt_status.done;

    // saturate the row count
    assign w_cur_inc = (w_pt_status.is_prime && (r_cur != mpcr_pkg::COUNT_MAX))
                       ? r_cur + mpcr_pkg::COUNT_W'(1) : r_cur;
    assign w_best_next = (w_cur_inc > r_best) ? w_cur_inc : r_best;
    // a row or the matrix ends when the position reaches or passes the size
    assign w_row_end = ((COL_CW+1)'(r_col) + (COL_CW+1)'(1)) >= (COL_CW+1)'(w_cols);
    assign w_mat_end = ((ROW_CW+1)'(r_row) + (ROW_CW+1)'(1)) >= (ROW_CW+1)'(w_rows);
    assign w_ram_wr  = w_elem_done && w_row_end;

    // ------------------------------------------------------------------
    // Per-row count store
    // ------------------------------------------------------------------
    mpcr_ram #(
        .WIDTH (mpcr_pkg::COUNT_W),
        .DEPTH (MAX_ROWS),
        .AW    (ROW_AW)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (r_row[ROW_AW-1:0]),
        .i_wr_data (w_cur_inc),
        .i_rd_en   (r_state == mpcr_pkg::ST_SCAN_RD),
        .i_rd_addr (r_scan[ROW_AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------
    // Result scan: hold one matching row back so the final one carries tlast
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_match    = (w_rd_data == r_best);
    assign w_stall    = w_match && r_pend_valid && !w_out_free;
    assign w_scan_end = ((ROW_CW+1)'(r_scan) + (ROW_CW+1)'(1)) >= (ROW_CW+1)'(w_rows);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpcr_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = mpcr_pkg::ST_TEST;
                end
            end
            mpcr_pkg::ST_TEST: begin
                if (w_pt_status.done) begin
                    priority if (w_row_end && w_mat_end && (w_best_next == '0)) begin
                        n_state = mpcr_pkg::ST_NONE;
                    end else if (w_row_end && w_mat_end) begin
                        n_state = mpcr_pkg::ST_SCAN_RD;
                    end else begin
                        n_state = mpcr_pkg::ST_IDLE;
                    end
                end
            end
            mpcr_pkg::ST_SCAN_RD: begin
                n_state = mpcr_pkg::ST_SCAN_CMP;
            end
            mpcr_pkg::ST_SCAN_CMP: begin
                if (!w_stall) begin
                    n_state = w_scan_end ? mpcr_pkg::ST_FLUSH : mpcr_pkg::ST_SCAN_RD;
                end
            end
            mpcr_pkg::ST_FLUSH, mpcr_pkg::ST_NONE: begin
                if (w_out_free) begin
                    n_state = mpcr_pkg::ST_IDLE;
                end
            end
            default: n_state = mpcr_pkg::ST_IDLE;
        endcase
    end

    // Outputs: what to load into the output register
    always_comb begin
        w_push       = 1'b0;
        w_push_row   = mpcr_pkg::ROW_IDX_W'(r_pend_row);
        w_push_count = r_best;
        w_push_none  = 1'b0;
        w_push_last  = 1'b0;
        unique case (r_state)
            mpcr_pkg::ST_SCAN_CMP: begin
                // a new match releases the one held back
                w_push = w_match && r_pend_valid && w_out_free;
            end
            mpcr_pkg::ST_FLUSH: begin
                w_push      = w_out_free && r_pend_valid;
                w_push_last = 1'b1;
            end
            mpcr_pkg::ST_NONE: begin
                w_push       = w_out_free;
                w_push_row   = '0;
                w_push_count = '0;
                w_push_none  = 1'b1;
                w_push_last  = 1'b1;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    // Sequencer and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mpcr_pkg::ST_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_cur        <= '0;
            r_best       <= '0;
            r_scan       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_elem_done) begin
                if (w_row_end) begin
                    r_cur  <= '0;
                    r_col  <= '0;
                    r_best <= w_best_next;
                    r_row  <= w_mat_end ? '0 : r_row + ROW_CW'(1);
                    r_scan <= '0;
                end else begin
                    r_cur <= w_cur_inc;
                    r_col <= r_col + COL_CW'(1);
                end
            end
            if ((r_state == mpcr_pkg::ST_SCAN_CMP) && !w_stall) begin
                r_scan <= r_scan + ROW_CW'(1);
                if (w_match) begin
                    r_pend_valid <= 1'b1;
                end
            end
            // start a new run once the final result is loaded
            if (((r_state == mpcr_pkg::ST_FLUSH) || (r_state == mpcr_pkg::ST_NONE))
                && w_out_free) begin
                r_best       <= '0;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mpcr_pkg::ST_SCAN_CMP) && !w_stall && w_match) begin
            r_pend_row <= r_scan[ROW_AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on push, drop on transaction
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_row   <= w_push_row;
            r_out_count <= w_push_count;
            r_out_none  <= w_push_none;
            r_out_last  <= w_push_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(mpcr_pkg::OUT_DATA_W - mpcr_pkg::COUNT_W - mpcr_pkg::ROW_IDX_W)'(0),
                            r_out_count, r_out_row};
    assign m_axis_tuser  = r_out_none;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> w_pt_status.busy)
        else $error("primality unit did not start on an accepted element");

    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_pt_status.busy)
        else $error("input ready while the primality unit is busy");

    a_flush_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpcr_pkg::ST_FLUSH) |-> (r_best != '0))
        else $error("scan finished with a zero maximum");

    a_stall_holds_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mpcr_pkg::ST_SCAN_CMP) && w_stall)
        |=> ((r_state == mpcr_pkg::ST_SCAN_CMP) && $stable(r_scan)))
        else $error("scan advanced while its held result could not be loaded");

    a_none_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |-> (r_out_last && (r_out_count == '0)))
        else $error("no-prime result is not a single final zero-count result");

endmodule
